[rtl/nce_pkg.sv]
// ----------------------------------------------------------------------------
// nce_pkg
// Shared types, character codes and decimal tables for the numeric character
// reference escaper.
// ----------------------------------------------------------------------------
package nce_pkg;

    // largest code unit that passes through unchanged
    localparam logic [15:0] PASS_MAX = 16'h00FF;

    // ascii characters of the escape
    localparam logic [15:0] CH_AMP  = 16'h0026;
    localparam logic [15:0] CH_HASH = 16'h0023;
    localparam logic [15:0] CH_SEMI = 16'h003B;
    localparam logic [15:0] CH_ZERO = 16'h0030;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // decimal place of the leading digit (0 = ones ... 4 = ten thousands)
    typedef logic [2:0] nce_place_t;

    // one classified item as it sits in the queue
    typedef struct packed {
        logic [15:0] unit;
        logic        esc;
        nce_place_t  top_place;
    } nce_entry_t;

    // back sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_DIGIT,
        ST_SEMI
    } nce_state_t;

    // power of ten for a decimal place
    function automatic logic [16:0] pow10(input nce_place_t place);
        logic [16:0] val;
        unique case (place)
            3'd0:    val = 17'd1;
            3'd1:    val = 17'd10;
            3'd2:    val = 17'd100;
            3'd3:    val = 17'd1000;
            3'd4:    val = 17'd10000;
            default: val = 17'd0;
        endcase
        return val;
    endfunction

    // digit times the power of ten of a place
    function automatic logic [16:0] step_value(input nce_place_t place, input logic [3:0] d);
        logic [20:0] prod;
        prod = 21'(pow10(place)) * 21'(d);
        return prod[16:0];
    endfunction

endpackage

[rtl/numeric_char_ref_escaper.sv]
// ----------------------------------------------------------------------------
// numeric_char_ref_escaper
// Replaces UTF-16 code units above 255 by decimal numeric character
// references and passes all others through.
// ----------------------------------------------------------------------------
// A code unit of 255 or less leaves as one result with last set; a larger one
// leaves as '&', '#', three to five decimal digits and ';', with last on the
// ';'. The back sequencer emits one result character per cycle while the
// output register is empty or popped; digits are found one per cycle, most
// significant first, by comparing against the multiples of the place value.
// A queue of QUEUE_DEPTH classified items lets input run ahead of output,
// and the single output register is refilled in the same cycle its
// character is popped. The ports work like a queue: push/full on input,
// pop/empty on output.
// ----------------------------------------------------------------------------
module numeric_char_ref_escaper
#(
    parameter int QUEUE_DEPTH = nce_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] code_unit,
    input  logic        pop,
    output logic        empty,
    output logic [15:0] out_char,
    output logic        last
);

    nce_pkg::nce_entry_t wr_entry;
    nce_pkg::nce_entry_t rd_entry;
    logic                q_wr;
    logic                q_rd;
    logic                q_empty;

    // front: accept and classify
    nce_front u_front
    (
        .code_unit (code_unit),
        .push      (push),
        .q_full    (full),
        .q_wr      (q_wr),
        .q_entry   (wr_entry)
    );

    // queue between front and back
    nce_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_entry (wr_entry),
        .rd       (q_rd),
        .rd_entry (rd_entry),
        .full     (full),
        .empty    (q_empty)
    );

    // back: emit result characters
    nce_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_entry  (rd_entry),
        .q_rd     (q_rd),
        .pop      (pop),
        .empty    (empty),
        .out_char (out_char),
        .last     (last)
    );

endmodule

[rtl/nce_front.sv]
// ----------------------------------------------------------------------------
// nce_front
// Accepts code units and classifies them: pass-through or escape, and the
// decimal place of the leading digit for an escape.
// ----------------------------------------------------------------------------
module nce_front
(
    input  logic                [15:0] code_unit,
    input  logic                       push,
    input  logic                       q_full,
    output logic                       q_wr,
    output nce_pkg::nce_entry_t        q_entry
);

    // accept when the queue has room
    assign q_wr = push && !q_full;

    // classify the unit
    always_comb
    begin
        q_entry.unit = code_unit;
        q_entry.esc  = code_unit > nce_pkg::PASS_MAX;
        priority if (code_unit >= 16'd10000)
        begin
            q_entry.top_place = 3'd4;
        end
        else if (code_unit >= 16'd1000)
        begin
            q_entry.top_place = 3'd3;
        end
        else
        begin
            q_entry.top_place = 3'd2;
        end
    end

endmodule

[rtl/nce_fifo.sv]
// ----------------------------------------------------------------------------
// nce_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module nce_fifo
#(
    parameter int DEPTH = nce_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  nce_pkg::nce_entry_t wr_entry,
    input  logic                rd,
    output nce_pkg::nce_entry_t rd_entry,
    output logic                full,
    output logic                empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    nce_pkg::nce_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == FULL_CNT;
    assign empty    = count_reg == '0;
    assign rd_entry = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

[rtl/nce_back.sv]
// ----------------------------------------------------------------------------
// nce_back
// Sequencer that turns queued items into result characters, one per cycle
// while the output is empty or popped, into a single output register.
// ----------------------------------------------------------------------------
module nce_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  nce_pkg::nce_entry_t        q_entry,
    output logic                       q_rd,
    input  logic                       pop,
    output logic                       empty,
    output logic                [15:0] out_char,
    output logic                       last
);

    nce_pkg::nce_state_t state_reg, state_next;
    logic [15:0]         rem_reg, rem_next;
    nce_pkg::nce_place_t place_reg, place_next;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;

    logic                advance;
    logic [9:1]          ge;
    logic [3:0]          digit;
    logic [16:0]         sub;

    assign empty    = !out_valid_reg;
    assign out_char = out_char_reg;
    assign last     = out_last_reg;

    // output register can take a new character
    assign advance = !out_valid_reg || pop;

    // leading digit of the remainder at the current place
    always_comb
    begin
        for (int d = 1; d < 10; d++)
        begin
            ge[d] = {1'b0, rem_reg} >= nce_pkg::step_value(place_reg, 4'(d));
        end
        digit = 4'($countones(ge));
        sub   = nce_pkg::step_value(place_reg, digit);
    end

    // next state and emitted character
    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        place_next     = place_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        q_rd           = 1'b0;
        if (advance)
        begin
            out_valid_next = 1'b0;
            unique case (state_reg)
                nce_pkg::ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        q_rd           = 1'b1;
                        out_valid_next = 1'b1;
                        if (q_entry.esc)
                        begin
                            out_char_next = nce_pkg::CH_AMP;
                            out_last_next = 1'b0;
                            rem_next      = q_entry.unit;
                            place_next    = q_entry.top_place;
                            state_next    = nce_pkg::ST_HASH;
                        end
                        else
                        begin
                            out_char_next = q_entry.unit;
                            out_last_next = 1'b1;
                        end
                    end
                end
                nce_pkg::ST_HASH:
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = nce_pkg::CH_HASH;
                    out_last_next  = 1'b0;
                    state_next     = nce_pkg::ST_DIGIT;
                end
                nce_pkg::ST_DIGIT:
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = nce_pkg::CH_ZERO + {12'd0, digit};
                    out_last_next  = 1'b0;
                    rem_next       = rem_reg - sub[15:0];
                    if (place_reg == 3'd0)
                    begin
                        state_next = nce_pkg::ST_SEMI;
                    end
                    else
                    begin
                        place_next = place_reg - 3'd1;
                    end
                end
                nce_pkg::ST_SEMI:
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = nce_pkg::CH_SEMI;
                    out_last_next  = 1'b1;
                    state_next     = nce_pkg::ST_IDLE;
                end
                default:
                begin
                    state_next = nce_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nce_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        place_reg    <= place_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule
